// ===== src/dfa_word_recognizer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// dfa word recognizer assertion macros
// shared assertion forms for the recognizer top level
// ----------------------------------------------------------------------------
`ifndef DFA_WORD_RECOGNIZER_UNIT_DEFINES_SVH
`define DFA_WORD_RECOGNIZER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DFAWR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DFAWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dfawr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfa word recognizer package
// shared constants, operation codes and control/status types
// ----------------------------------------------------------------------------
package dfawr_pkg;

    localparam int MAX_STATES   = 16;
    localparam int NUM_EVENTS   = 256;
    localparam int STATE_W      = 4;
    localparam int EVENT_W      = 8;
    localparam int ADDR_W       = STATE_W + EVENT_W;
    localparam int TABLE_DEPTH  = MAX_STATES * NUM_EVENTS;
    localparam int NUM_STATES_W = 5;
    localparam int OP_W         = 2;

    localparam logic [NUM_STATES_W-1:0] NUM_STATES_RESET = NUM_STATES_W'(MAX_STATES);
    localparam logic [NUM_STATES_W-1:0] NUM_STATES_MAX   = NUM_STATES_W'(MAX_STATES);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_SYMBOL = 2'd2;
    localparam logic [OP_W-1:0] OP_END    = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] dest;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic look;
        logic sweep;
        logic cfg_we;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic word_dead;
        logic out_busy;
    } t_sts;

endpackage

// ===== src/dfawr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfa word recognizer controller
// sequences table clearing, table lookups and input flow control
// ----------------------------------------------------------------------------
module dfawr_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [dfawr_pkg::OP_W-1:0] i_operation,
    input  logic                      i_cfg_valid,
    input  logic                      i_out_stall,
    input  dfawr_pkg::t_sts           i_sts,
    output logic                      o_in_stall,
    output dfawr_pkg::t_cmd           o_cmd
);
    import dfawr_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       stall;
    logic       accept;

    always_comb begin
        stall  = (r_state != ST_IDLE) ||
                 ((i_operation == OP_END) && i_sts.out_busy && i_out_stall);
        accept = i_in_valid && !stall;
    end

    assign o_in_stall   = stall;
    assign o_cmd.accept = accept;
    assign o_cmd.look   = (r_state == ST_LOOK);
    assign o_cmd.sweep  = (r_state == ST_CLEAR) && !i_cfg_valid;
    assign o_cmd.cfg_we = i_cfg_valid;

    always_comb begin
        n_state = r_state;
        priority if (i_cfg_valid) begin
            n_state = ST_CLEAR;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    if (i_sts.sweep_last) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_operation)
                            OP_CLEAR:  n_state = ST_CLEAR;
                            OP_ADD:    n_state = ST_LOOK;
                            OP_SYMBOL: n_state = i_sts.word_dead ? ST_IDLE : ST_LOOK;
                            OP_END:    n_state = ST_IDLE;
                            default:   n_state = ST_IDLE;
                        endcase
                    end
                end
                ST_LOOK: n_state = ST_IDLE;
                default: n_state = ST_CLEAR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/dfawr_datapath.sv =====
// ----------------------------------------------------------------------------
// dfa word recognizer datapath
// transition table memory, walk state, register and result output
// ----------------------------------------------------------------------------
module dfawr_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dfawr_pkg::t_cmd                   i_cmd,
    input  logic [dfawr_pkg::OP_W-1:0]         i_operation,
    input  logic [dfawr_pkg::STATE_W-1:0]      i_from_state,
    input  logic [dfawr_pkg::STATE_W-1:0]      i_to_state,
    input  logic [dfawr_pkg::EVENT_W-1:0]      i_event_req,
    input  logic [dfawr_pkg::NUM_STATES_W-1:0] i_cfg_data,
    input  logic                              i_out_stall,
    output dfawr_pkg::t_sts                   o_sts,
    output logic                              o_out_valid,
    output logic                              o_accepted
);
    import dfawr_pkg::*;

    t_entry                    mem [TABLE_DEPTH];
    t_entry                    r_rd;
    logic [ADDR_W-1:0]         r_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;
    t_entry                    wr_data;
    logic                      wr_en;
    logic [ADDR_W-1:0]         r_sweep_cnt;
    logic [NUM_STATES_W-1:0]   r_num_states;
    logic [NUM_STATES_W-1:0]   eff_states;
    logic [STATE_W-1:0]        last_state;
    logic [STATE_W-1:0]        r_cur;
    logic                      r_dead;
    logic [OP_W-1:0]           r_op;
    logic [STATE_W-1:0]        r_to;
    logic                      r_add_ok;
    logic                      add_ok;
    logic                      r_out_valid;
    logic                      r_accepted;

    // effective state count: zero acts as one, large values clip
    always_comb begin
        if (r_num_states == '0) begin
            eff_states = NUM_STATES_W'(1);
        end else if (r_num_states > NUM_STATES_MAX) begin
            eff_states = NUM_STATES_MAX;
        end else begin
            eff_states = r_num_states;
        end
        last_state = STATE_W'(eff_states - NUM_STATES_W'(1));
        add_ok     = ({1'b0, i_from_state} < eff_states) &&
                     ({1'b0, i_to_state} < eff_states);
        rd_addr    = (i_operation == OP_ADD) ? {i_from_state, i_event_req}
                                             : {r_cur, i_event_req};
    end

    always_comb begin
        wr_en         = 1'b0;
        wr_addr       = r_addr;
        wr_data.valid = 1'b1;
        wr_data.dest  = r_to;
        if (i_cmd.sweep) begin
            wr_en         = 1'b1;
            wr_addr       = r_sweep_cnt;
            wr_data.valid = 1'b0;
            wr_data.dest  = '0;
        end else if (i_cmd.look && (r_op == OP_ADD) && r_add_ok && !r_rd.valid) begin
            wr_en = 1'b1;
        end
    end

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= mem[rd_addr];
        end
    end

    // latched item for the lookup cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_operation;
            r_to     <= i_to_state;
            r_add_ok <= add_ok;
            r_addr   <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_cnt <= '0;
        end else if (i_cmd.cfg_we || (i_cmd.accept && (i_operation == OP_CLEAR))) begin
            r_sweep_cnt <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep_cnt <= r_sweep_cnt + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= NUM_STATES_RESET;
        end else if (i_cmd.cfg_we) begin
            r_num_states <= i_cfg_data;
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_dead <= 1'b0;
        end else if (i_cmd.cfg_we) begin
            r_cur  <= '0;
            r_dead <= 1'b0;
        end else if (i_cmd.accept &&
                     ((i_operation == OP_CLEAR) || (i_operation == OP_END))) begin
            r_cur  <= '0;
            r_dead <= 1'b0;
        end else if (i_cmd.look && (r_op == OP_SYMBOL)) begin
            if (r_rd.valid) begin
                r_cur <= r_rd.dest;
            end else begin
                r_dead <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.accept && (i_operation == OP_END)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_operation == OP_END)) begin
            r_accepted <= !r_dead && (r_cur == last_state);
        end
    end

    assign o_sts.sweep_last = (r_sweep_cnt == ADDR_W'(TABLE_DEPTH - 1));
    assign o_sts.word_dead  = r_dead;
    assign o_sts.out_busy   = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_accepted;

endmodule

// ===== src/dfa_word_recognizer_unit.sv =====
// ----------------------------------------------------------------------------
// dfa word recognizer unit
// programmable table-driven automaton that accepts or rejects words
// ----------------------------------------------------------------------------
// An add-transition item or a symbol item needs a table lookup: the table
// is a memory with a registered read, so the entry is read in the accept
// cycle and resolved (written or followed) in the next. End of word, and a
// symbol on a word that is already dead, need no lookup; the result sits
// in an output register, so the next items are taken while it waits, and
// only a further end of word stalls behind it. Reset, a clear item and a
// write of num_states start a clearing pass over the 4096-entry table, one
// entry a cycle (a num_states write restarts it); no item is taken meanwhile.
module dfa_word_recognizer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [dfawr_pkg::OP_W-1:0]         i_operation,
    input  logic [dfawr_pkg::STATE_W-1:0]      i_from_state,
    input  logic [dfawr_pkg::STATE_W-1:0]      i_to_state,
    input  logic [dfawr_pkg::EVENT_W-1:0]      i_event_req,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_accepted,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dfawr_pkg::NUM_STATES_W-1:0] i_cfg_data
);
    import dfawr_pkg::*;

`include "dfa_word_recognizer_unit_defines.svh"

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    dfawr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_cfg_valid (i_cfg_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    dfawr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_operation  (i_operation),
        .i_from_state (i_from_state),
        .i_to_state   (i_to_state),
        .i_event_req  (i_event_req),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_accepted   (o_accepted)
    );

    `DFAWR_ASSERT_NEXT(a_add_looks_up, i_clk, i_rst_n, cmd.accept && (i_operation == OP_ADD) && !i_cfg_valid, cmd.look, "add item not followed by lookup")
    `DFAWR_ASSERT_NEXT(a_look_one_cycle, i_clk, i_rst_n, cmd.look, !cmd.look, "lookup lasted more than one cycle")
    `DFAWR_ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, cmd.accept && (i_operation == OP_END), o_out_valid, "end of word gave no result")
    `DFAWR_ASSERT_NOW(a_no_accept_in_sweep, i_clk, i_rst_n, cmd.sweep || cmd.look, !cmd.accept, "item taken while busy")

endmodule
